// ----- hw/rtl/fixed_point_alu_assert.svh -----
// Assertion macros for the checker of the fixed-point ALU.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Implication checked on every rising edge of clk, off while arst_n is low.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold on every rising edge of clk out of reset.
`define FPA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/fpa_pkg.sv -----
`default_nettype none
package fpa_pkg;

	localparam int unsigned FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_GE       = 4'd5,
		OP_LT       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               flag;
		logic               div_error;
	} rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fixed_point_alu.sv -----
`default_nettype none
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits
// (Q24.8 by default). Raise start with an item on req; while busy is low
// (it always is) the item is taken at that edge, and a new item may follow
// in every cycle. Each item yields exactly one response on rsp, shown for a
// single cycle with done high, in the order the items went in. The receiver
// cannot stall the block, so it must take rsp whenever done is high.
// Every item passes from start to done through one input stage holding the
// 32x32 multiplier, one stage per quotient bit of the restoring divider
// (32 + FRAC_BITS bits) and one output stage. All operations travel down
// the same pipeline so order is kept.
// Divide by zero returns 0 with div_error set; quotients that overflow wrap.
module fixed_point_alu #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire fpa_pkg::req_t req,
	output logic               done,
	output fpa_pkg::rsp_t      rsp
);

	// Dividend width: |a| shifted left by the fraction bits.
	localparam int unsigned DW = 32 + FRAC_BITS;

	typedef struct packed {
		logic               valid;
		logic               is_div;
		logic               neg;
		logic               dz;
		logic signed [31:0] res;
		logic               flag;
	} meta_t;

	// Input stage
	logic               valid_s1;
	fpa_pkg::op_t       op_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	logic signed [63:0] prod_s1;
	logic [31:0]        abs_a;
	logic [31:0]        abs_b;

	// Divider stages, index k is the register after quotient step k
	meta_t       meta_sn [DW];
	logic [DW-1:0] dvd_sn [DW];
	logic [31:0] rem_sn  [DW];
	logic [31:0] dvs_sn  [DW];

	meta_t       meta_in;
	logic [31:0] qneg;
	logic [31:0] quot;

	// The receiver cannot hold results off, so never push back.
	assign busy = 1'b0;

	assign abs_a = req.operand_a[31] ? 32'(-req.operand_a) : 32'(req.operand_a);
	assign abs_b = req.operand_b[31] ? 32'(-req.operand_b) : 32'(req.operand_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Capture the item and form the full product in the same cycle.
	always_ff @(posedge clk) begin
		op_s1   <= fpa_pkg::op_t'(req.opcode);
		a_s1    <= req.operand_a;
		b_s1    <= req.operand_b;
		prod_s1 <= 64'(req.operand_a) * 64'(req.operand_b);
	end

	// Divider operands, registered alongside the item
	logic [DW-1:0] dvd_s1;
	logic [31:0]   dvs_s1;
	logic          neg_s1;
	always_ff @(posedge clk) begin
		dvd_s1 <= {abs_a, {FRAC_BITS{1'b0}}};
		dvs_s1 <= abs_b;
		neg_s1 <= req.operand_a[31] ^ req.operand_b[31];
	end

	// Everything but the quotient is settled here and rides down the pipe.
	always_comb begin
		meta_in        = '0;
		meta_in.valid  = valid_s1;
		meta_in.neg    = neg_s1;
		meta_in.dz     = (b_s1 == 32'sd0);
		unique case (op_s1)
			fpa_pkg::OP_ADD:      meta_in.res = a_s1 + b_s1;
			fpa_pkg::OP_SUB:      meta_in.res = a_s1 - b_s1;
			fpa_pkg::OP_MUL:      meta_in.res = prod_s1[FRAC_BITS +: 32];
			fpa_pkg::OP_DIV:      meta_in.is_div = 1'b1;
			fpa_pkg::OP_GT:       meta_in.flag = (a_s1 > b_s1);
			fpa_pkg::OP_GE:       meta_in.flag = (a_s1 >= b_s1);
			fpa_pkg::OP_LT:       meta_in.flag = (a_s1 < b_s1);
			fpa_pkg::OP_LE:       meta_in.flag = (a_s1 <= b_s1);
			fpa_pkg::OP_EQ:       meta_in.flag = (a_s1 == b_s1);
			fpa_pkg::OP_NE:       meta_in.flag = (a_s1 != b_s1);
			fpa_pkg::OP_MIN:      meta_in.res = (a_s1 <= b_s1) ? a_s1 : b_s1;
			fpa_pkg::OP_MAX:      meta_in.res = (a_s1 >= b_s1) ? a_s1 : b_s1;
			fpa_pkg::OP_INC:      meta_in.res = a_s1 + 32'sd1;
			fpa_pkg::OP_DEC:      meta_in.res = a_s1 - 32'sd1;
			fpa_pkg::OP_TO_INT:   meta_in.res = a_s1 >>> FRAC_BITS;
			fpa_pkg::OP_FROM_INT: meta_in.res = a_s1 << FRAC_BITS;
			default:              meta_in.res = '0;
		endcase
	end

	// Restoring divider: one quotient bit per stage. The dividend register
	// shifts out its top bit each step and takes the new quotient bit in
	// at the bottom, so after DW steps it holds the quotient magnitude.
	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [DW-1:0] dvd_in;
		logic [31:0]   rem_in;
		logic [31:0]   dvs_in;
		meta_t         meta_pv;
		logic [32:0]   trial;
		logic [32:0]   diff;
		logic          qbit;

		if (k == 0) begin : g_first
			assign dvd_in  = dvd_s1;
			assign rem_in  = '0;
			assign dvs_in  = dvs_s1;
			assign meta_pv = meta_in;
		end else begin : g_next
			assign dvd_in  = dvd_sn[k-1];
			assign rem_in  = rem_sn[k-1];
			assign dvs_in  = dvs_sn[k-1];
			assign meta_pv = meta_sn[k-1];
		end

		assign trial = {rem_in, dvd_in[DW-1]};
		assign diff  = trial - {1'b0, dvs_in};
		assign qbit  = !diff[32];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_sn[k] <= '0;
			end else begin
				meta_sn[k] <= meta_pv;
			end
		end

		always_ff @(posedge clk) begin
			dvs_sn[k]         <= dvs_in;
			rem_sn[k]         <= qbit ? diff[31:0] : trial[31:0];
			dvd_sn[k]         <= {dvd_in[DW-2:0], qbit};
		end
	end

	// Apply the sign and truncate to 32 bits; truncation toward zero
	// follows from dividing magnitudes.
	assign quot = dvd_sn[DW-1][31:0];
	assign qneg = meta_sn[DW-1].neg ? 32'(-quot) : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= meta_sn[DW-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp.flag      <= meta_sn[DW-1].flag;
		rsp.div_error <= meta_sn[DW-1].is_div && meta_sn[DW-1].dz;
		if (meta_sn[DW-1].is_div) begin
			rsp.result <= meta_sn[DW-1].dz ? 32'sd0 : $signed(qneg);
		end else begin
			rsp.result <= meta_sn[DW-1].res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/fpa_checker.sv -----
`default_nettype none
`include "fixed_point_alu_assert.svh"
module fpa_checker #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire fpa_pkg::req_t req,
	input wire logic          done,
	input wire fpa_pkg::rsp_t rsp
);

	localparam int unsigned LAT = FRAC_BITS + 34;

	`FPA_ASSERT_IMP(a_item_out, start && !busy, ##LAT done, "item taken without a response")
	`FPA_ASSERT_IMP(a_no_ghost, done, $past(start && !busy, LAT), "response without an item")
	`FPA_ASSERT_IMP(a_dz_zero, done && rsp.div_error, rsp.result == 32'sd0 && !rsp.flag,
		"divide by zero with non-zero result")
	`FPA_ASSERT_IMP(a_div_only, start && !busy && req.opcode != fpa_pkg::OP_DIV,
		##LAT !rsp.div_error, "divide error on another operation")

endmodule

bind fixed_point_alu fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
`default_nettype wire
